### sv/dictionary_mismatch_code_decompressor_top_defines.svh
// assertion macros for the decompressor rtl
// expects clk and rst in the scope of each use
`ifndef DICTIONARY_MISMATCH_CODE_DECOMPRESSOR_TOP_DEFINES_SVH
`define DICTIONARY_MISMATCH_CODE_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication
`define DMCD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmcd same-cycle check failed");

// next-cycle implication
`define DMCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmcd next-cycle check failed");

`endif

### sv/dmcd_pkg.sv
// types, constants and helpers for the dictionary mismatch code decompressor
// used by every rtl file of the block; depends on nothing
`default_nettype none
package dmcd_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int DICT_SIZE  = 8;
  localparam int IDX_W      = 3;
  localparam int POS_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int MAX_RUN    = 7;
  localparam int RUN_W      = 3;
  localparam int PEND_MAX   = 33;
  localparam int BUF_W      = PEND_MAX + WORD_WIDTH;
  localparam int CNT_W      = 7;
  localparam int LEN_EXACT  = 5;
  localparam int LEN_PAIR   = 10;
  localparam int LEN_TWO    = 15;
  localparam int LEN_RAW    = 2 + WORD_WIDTH;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_TWO   = 2'd2,
    KIND_RAW   = 2'd3
  } code_kind_t;

  typedef enum logic {
    FRONT_IDLE   = 1'b0,
    FRONT_DECODE = 1'b1
  } front_state_t;

  // one parsed code: prefix, the 32 bits that follow it and the last-in-run flag
  typedef struct packed {
    code_kind_t            kind;
    logic [WORD_WIDTH-1:0] body;
    logic                  last;
  } code_t;

  function automatic logic [CNT_W-1:0] code_len(input code_kind_t k);
    logic [CNT_W-1:0] len;
    unique case (k)
      KIND_EXACT: len = CNT_W'(LEN_EXACT);
      KIND_PAIR:  len = CNT_W'(LEN_PAIR);
      KIND_TWO:   len = CNT_W'(LEN_TWO);
      KIND_RAW:   len = CNT_W'(LEN_RAW);
      default:    len = CNT_W'(LEN_RAW);
    endcase
    return len;
  endfunction

  // position 0 is the msb
  function automatic logic [WORD_WIDTH-1:0] flip_mask(input logic [POS_W-1:0] pos);
    return {1'b1, {(WORD_WIDTH-1){1'b0}}} >> pos;
  endfunction

endpackage
`default_nettype wire

### sv/dmcd_in_if.sv
// compressed word channel: valid, ready and payload
// depends on dmcd_pkg
`default_nettype none
interface dmcd_in_if;
  logic                            valid;
  logic                            ready;
  logic [dmcd_pkg::WORD_WIDTH-1:0] compressed_word;
  logic                            final_word;

  modport source (output valid, output compressed_word, output final_word, input ready);
  modport sink (input valid, input compressed_word, input final_word, output ready);
endinterface
`default_nettype wire

### sv/dmcd_out_if.sv
// decompressed word channel: valid, ready and payload
// depends on dmcd_pkg
`default_nettype none
interface dmcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [dmcd_pkg::WORD_WIDTH-1:0] plain_word;
  logic [1:0]                      code_kind;
  logic                            run_last;

  modport source (output valid, output plain_word, output code_kind, output run_last,
                  input ready);
  modport sink (input valid, input plain_word, input code_kind, input run_last,
                output ready);
endinterface
`default_nettype wire

### sv/dmcd_front.sv
// front end: bit buffer, code framing and run tracking, one code per cycle while the queue has room
// depends on dmcd_pkg, dmcd_in_if and the assertion macro header
`default_nettype none
`include "dictionary_mismatch_code_decompressor_top_defines.svh"
module dmcd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  dmcd_in_if.sink             in_ch,
  output dmcd_pkg::code_t     push_data,
  output logic                push_valid,
  input  wire logic           push_ready
);

  dmcd_pkg::front_state_t             state, state_next;
  logic [dmcd_pkg::BUF_W-1:0]         buf_q;
  logic [dmcd_pkg::CNT_W-1:0]         cnt;
  logic [dmcd_pkg::RUN_W-1:0]         run;
  logic                               fin;

  dmcd_pkg::code_kind_t               kind, kind_after;
  logic [dmcd_pkg::CNT_W-1:0]         need, need_after, cnt_after;
  logic [dmcd_pkg::BUF_W-1:0]         buf_shift;
  logic                               fits, more, done, accept, emit;

  assign kind       = dmcd_pkg::code_kind_t'(buf_q[dmcd_pkg::BUF_W-1 -: 2]);
  assign need       = dmcd_pkg::code_len(kind);
  assign fits       = cnt >= need;
  assign cnt_after  = cnt - need;

  always_comb begin
    unique case (kind)
      dmcd_pkg::KIND_EXACT: buf_shift = buf_q << dmcd_pkg::LEN_EXACT;
      dmcd_pkg::KIND_PAIR:  buf_shift = buf_q << dmcd_pkg::LEN_PAIR;
      dmcd_pkg::KIND_TWO:   buf_shift = buf_q << dmcd_pkg::LEN_TWO;
      dmcd_pkg::KIND_RAW:   buf_shift = buf_q << dmcd_pkg::LEN_RAW;
      default:              buf_shift = buf_q << dmcd_pkg::LEN_RAW;
    endcase
  end

  // does another code follow in this run
  assign kind_after = dmcd_pkg::code_kind_t'(buf_shift[dmcd_pkg::BUF_W-1 -: 2]);
  assign need_after = dmcd_pkg::code_len(kind_after);
  assign more       = cnt_after >= need_after;

  assign done   = (state == dmcd_pkg::FRONT_DECODE) &&
                  (!fits || (run == dmcd_pkg::RUN_W'(dmcd_pkg::MAX_RUN)));
  assign accept = in_ch.valid && in_ch.ready;
  assign emit   = push_valid && push_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      dmcd_pkg::FRONT_IDLE:   if (accept) state_next = dmcd_pkg::FRONT_DECODE;
      dmcd_pkg::FRONT_DECODE: if (done) state_next = dmcd_pkg::FRONT_IDLE;
      default:                state_next = dmcd_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = (state == dmcd_pkg::FRONT_IDLE);
    push_valid      = (state == dmcd_pkg::FRONT_DECODE) && fits &&
                      (run != dmcd_pkg::RUN_W'(dmcd_pkg::MAX_RUN));
    push_data.kind  = kind;
    push_data.body  = buf_q[dmcd_pkg::BUF_W-3 -: dmcd_pkg::WORD_WIDTH];
    push_data.last  = !more || (run == dmcd_pkg::RUN_W'(dmcd_pkg::MAX_RUN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmcd_pkg::FRONT_IDLE;
      buf_q <= '0;
      cnt   <= '0;
      run   <= '0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        // append the new word right after the pending bits
        buf_q <= buf_q | ({in_ch.compressed_word, {dmcd_pkg::PEND_MAX{1'b0}}} >> cnt);
        cnt   <= cnt + dmcd_pkg::CNT_W'(dmcd_pkg::WORD_WIDTH);
        run   <= '0;
        fin   <= in_ch.final_word;
      end else if (emit) begin
        buf_q <= buf_shift;
        cnt   <= cnt_after;
        run   <= run + 1'b1;
      end else if (done) begin
        if (fin) begin
          buf_q <= '0;
          cnt   <= '0;
        end else if (cnt > dmcd_pkg::CNT_W'(dmcd_pkg::PEND_MAX)) begin
          // keep only the oldest bits that fit
          buf_q <= buf_q & {{dmcd_pkg::PEND_MAX{1'b1}}, {dmcd_pkg::WORD_WIDTH{1'b0}}};
          cnt   <= dmcd_pkg::CNT_W'(dmcd_pkg::PEND_MAX);
        end
      end
    end
  end

  `DMCD_ASSERT_IMPL(a_idle_pending, state == dmcd_pkg::FRONT_IDLE,
                    cnt <= dmcd_pkg::CNT_W'(dmcd_pkg::PEND_MAX))
  `DMCD_ASSERT_IMPL(a_run_cap, push_valid, run < dmcd_pkg::RUN_W'(dmcd_pkg::MAX_RUN))
  `DMCD_ASSERT_NEXT(a_final_clears, done && fin, cnt == '0)

endmodule
`default_nettype wire

### sv/dmcd_queue.sv
// short queue of parsed codes between front and back
// depends on dmcd_pkg
`default_nettype none
module dmcd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dmcd_pkg::code_t  push_data,
  input  wire logic             push_valid,
  output logic                  push_ready,
  output dmcd_pkg::code_t       pop_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dmcd_pkg::code_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/dmcd_back.sv
// back end: dictionary, bit flips and output register
// depends on dmcd_pkg and dmcd_out_if
`default_nettype none
module dmcd_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [dmcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmcd_pkg::WORD_WIDTH-1:0] cfg_data,
  input  wire dmcd_pkg::code_t                 pop_data,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  dmcd_out_if.source                           out_ch
);

  localparam int W = dmcd_pkg::WORD_WIDTH;

  logic [W-1:0]                 dict [dmcd_pkg::DICT_SIZE];
  logic [dmcd_pkg::IDX_W-1:0]   idx;
  logic [dmcd_pkg::POS_W-1:0]   pos_a, pos_b;
  logic [W-1:0]                 entry, mask_a, word;
  logic                         out_valid, take;

  assign pos_a  = pop_data.body[W-1 -: dmcd_pkg::POS_W];
  assign pos_b  = pop_data.body[W-1-dmcd_pkg::POS_W -: dmcd_pkg::POS_W];
  assign mask_a = dmcd_pkg::flip_mask(pos_a);

  always_comb begin
    unique case (pop_data.kind)
      dmcd_pkg::KIND_EXACT: idx = pop_data.body[W-1 -: dmcd_pkg::IDX_W];
      dmcd_pkg::KIND_PAIR:  idx = pop_data.body[W-1-dmcd_pkg::POS_W -: dmcd_pkg::IDX_W];
      dmcd_pkg::KIND_TWO:   idx = pop_data.body[W-1-2*dmcd_pkg::POS_W -: dmcd_pkg::IDX_W];
      default:              idx = '0;
    endcase
  end

  assign entry = dict[idx];

  always_comb begin
    unique case (pop_data.kind)
      dmcd_pkg::KIND_EXACT: word = entry;
      // second flip past the lsb falls off the shift
      dmcd_pkg::KIND_PAIR:  word = entry ^ (mask_a | (mask_a >> 1));
      dmcd_pkg::KIND_TWO:   word = entry ^ mask_a ^ dmcd_pkg::flip_mask(pos_b);
      default:              word = pop_data.body;
    endcase
  end

  assign pop_ready    = !out_valid || out_ch.ready;
  assign take         = pop_valid && pop_ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dmcd_pkg::DICT_SIZE; i++) dict[i] <= '0;
    end else if (cfg_valid) begin
      dict[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.plain_word <= word;
      out_ch.code_kind  <= pop_data.kind;
      out_ch.run_last   <= pop_data.last;
    end
  end

endmodule
`default_nettype wire

### sv/dictionary_mismatch_code_decompressor_top.sv
// top level of the dictionary mismatch code decompressor
// depends on dmcd_pkg, dmcd_in_if, dmcd_out_if, dmcd_front, dmcd_queue, dmcd_back
//
//   channel   direction  handshake             payload
//   in_ch     in         valid / ready         compressed_word, final_word
//   out_ch    out        valid / ready         plain_word, code_kind, run_last
//   cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// an input word holds the front through an accept step, the framing of each code
//   it completes (0..7) through the bit buffer, and a closing step
// results leave one per cycle while out_ch is ready and the queue holds codes, via the queue and the output register
// synchronous reset clears the bit buffer, the queue, the output valid flag and the dictionary
// a stalled output fills the queue of QUEUE_DEPTH codes before the front stops framing
`default_nettype none
module dictionary_mismatch_code_decompressor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  dmcd_in_if.sink                              in_ch,
  dmcd_out_if.source                           out_ch,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dmcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmcd_pkg::WORD_WIDTH-1:0] cfg_data
);

  dmcd_pkg::code_t push_data, pop_data;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  dmcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  dmcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  dmcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
